>>> hw/rtl/tmmrg_pkg.sv
package tmmrg_pkg;

	localparam int TableDepth = 256;
	localparam int IdxW = $clog2(TableDepth);
	// The table index is taken from the state starting at this bit.
	localparam int IdxLsb = 12;

	localparam logic [15:0] MwcHighMul = 16'd36969;
	localparam logic [15:0] MwcLowMul = 16'd18000;
	localparam logic [31:0] LcgMul = 32'd69069;
	localparam logic [31:0] LcgAdd = 32'd1234567;
	localparam logic [31:0] SeedMwcHigh = 32'd12345;
	localparam logic [31:0] SeedMwcLow = 32'd65435;
	localparam logic [31:0] SeedXorshift = 32'd34221;
	localparam logic [31:0] SeedLcg = 32'd12345;

	typedef enum logic [1:0] {
		ACT_DRAW32 = 2'd0,
		ACT_DRAW64 = 2'd1,
		ACT_RESEED = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_FIRST_MIX,
		ST_SECOND_READ,
		ST_LAST_MIX
	} eng_state_t;

	// Multiply part of a draw: ((36969*hi) << 16) + 18000*lo, modulo 2^32.
	function automatic logic [31:0] draw_mix(input logic [31:0] s);
		logic [31:0] prod_hi;
		logic [31:0] prod_lo;
		prod_hi = {16'd0, s[31:16]} * {16'd0, MwcHighMul};
		prod_lo = {16'd0, s[15:0]} * {16'd0, MwcLowMul};
		return {prod_hi[15:0], 16'd0} + prod_lo;
	endfunction

	function automatic logic [31:0] mwc_step(input logic [31:0] x, input logic [15:0] mul);
		logic [31:0] prod;
		prod = {16'd0, x[15:0]} * {16'd0, mul};
		return prod + {16'd0, x[31:16]};
	endfunction

	function automatic logic [31:0] xorshift_step(input logic [31:0] x);
		logic [31:0] t;
		t = x ^ (x << 17);
		t = t ^ (t >> 13);
		t = t ^ (t << 5);
		return t;
	endfunction

	function automatic logic [31:0] fill_word(input logic [31:0] hi, input logic [31:0] lo,
			input logic [31:0] lcg, input logic [31:0] xs);
		logic [31:0] mwc;
		mwc = {hi[15:0], 16'd0} + lo;
		return (mwc ^ lcg) + xs;
	endfunction

endpackage

>>> hw/rtl/table_mixed_mwc_random_generator.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------
// input    | in_valid / in_stall | action[1:0], seed_value[31:0]
// output   | out_valid/out_stall | random_value[63:0], state_out[31:0]
//
// A 32-bit draw reads the mixing table at state bits 19:12 while the multiplies are
// registered, then folds the table word into the state. A 64-bit draw does this twice,
// through ST_FIRST_MIX, ST_SECOND_READ and ST_LAST_MIX; reseed and the unused action
// finish in the accept cycle. After reset the table is filled one word a cycle; input
// stays stalled until the fill ends. A result waiting on out_stall holds the last step of
// a draw; a new draw is still taken while the output register is full and the engine is free.
module table_mixed_mwc_random_generator
	import tmmrg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] seed_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] random_value,
	output logic [31:0] state_out
);

	logic [31:0] mem [TableDepth];
	logic [31:0] rd_q;

	eng_state_t st_q, st_d;
	logic [31:0] state_q;

	logic [31:0] fill_hi_q, fill_lo_q, fill_lcg_q, fill_xs_q;
	logic [IdxW:0] fill_cnt_q;
	logic fill_wr_s1;
	logic [IdxW-1:0] fill_addr_s1;

	logic [31:0] mixed_s1;
	logic [31:0] hi_word_q;
	logic wide_q;

	logic out_valid_q;
	logic [63:0] random_value_q;
	logic [31:0] state_out_q;

	action_t act;
	logic quick, out_free, accept, read_en, final_load, quick_load, fill_step;
	logic [31:0] new_word;

	assign act = action_t'(action);
	assign quick = (act == ACT_RESEED) || (act == ACT_NONE);
	assign out_free = !out_valid_q || !out_stall;
	assign accept = in_valid && !in_stall;
	assign new_word = mixed_s1 ^ ~rd_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_FILL: begin
				if (fill_cnt_q[IdxW] && !fill_wr_s1) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && !quick) st_d = (act == ACT_DRAW64) ? ST_FIRST_MIX : ST_LAST_MIX;
			end
			ST_FIRST_MIX: st_d = ST_SECOND_READ;
			ST_SECOND_READ: st_d = ST_LAST_MIX;
			ST_LAST_MIX: begin
				if (out_free) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (st_q != ST_IDLE) || (quick && !out_free);
		read_en = (in_valid && !in_stall && !quick) || (st_q == ST_SECOND_READ);
		final_load = (st_q == ST_LAST_MIX) && out_free;
		quick_load = in_valid && !in_stall && quick;
		fill_step = (st_q == ST_FILL) && !fill_cnt_q[IdxW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_FILL;
			state_q <= '0;
			fill_hi_q <= SeedMwcHigh;
			fill_lo_q <= SeedMwcLow;
			fill_lcg_q <= SeedLcg;
			fill_xs_q <= SeedXorshift;
			fill_cnt_q <= '0;
			fill_wr_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (quick_load && act == ACT_RESEED) begin
				state_q <= seed_value;
			end else if (st_q == ST_FIRST_MIX || final_load) begin
				state_q <= new_word;
			end
			if (fill_step) begin
				fill_hi_q <= mwc_step(fill_hi_q, MwcHighMul);
				fill_lo_q <= mwc_step(fill_lo_q, MwcLowMul);
				fill_lcg_q <= fill_lcg_q * LcgMul + LcgAdd;
				fill_xs_q <= xorshift_step(fill_xs_q);
				fill_cnt_q <= fill_cnt_q + (IdxW + 1)'(1);
			end
			fill_wr_s1 <= fill_step;
			if (quick_load || final_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The fill word is formed from the generator registers in the cycle after they step.
	always_ff @(posedge clk) begin
		if (fill_wr_s1) mem[fill_addr_s1] <= fill_word(fill_hi_q, fill_lo_q, fill_lcg_q,
			fill_xs_q);
		if (read_en) rd_q <= mem[state_q[IdxLsb +: IdxW]];
	end

	always_ff @(posedge clk) begin
		fill_addr_s1 <= fill_cnt_q[IdxW-1:0];
		if (read_en) mixed_s1 <= draw_mix(state_q);
		if (st_q == ST_FIRST_MIX) hi_word_q <= new_word;
		if (accept) wide_q <= (act == ACT_DRAW64);
		if (quick_load) begin
			random_value_q <= '0;
			state_out_q <= (act == ACT_RESEED) ? seed_value : state_q;
		end else if (final_load) begin
			random_value_q <= {(wide_q ? hi_word_q : 32'd0), new_word};
			state_out_q <= new_word;
		end
	end

	assign out_valid = out_valid_q;
	assign random_value = random_value_q;
	assign state_out = state_out_q;

endmodule

>>> hw/rtl/tmmrg_checker.sv
module tmmrg_checker
	import tmmrg_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  action,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] random_value,
	input logic [31:0] state_out
);

	// A stalled result transaction keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(random_value) && $stable(state_out))
		else $error("output payload changed while stalled");

	// A draw ends with the new state in the low word; other actions report zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (random_value[31:0] == state_out) || (random_value == 64'd0))
		else $error("result word and state disagree");

	// A draw keeps the engine busy, so no new transaction is taken right behind it.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACT_DRAW32 || action == ACT_DRAW64) |=> in_stall)
		else $error("new transaction taken during a draw");

	// The table fill holds off input and output right after reset.
	assert property (@(posedge clk) $rose(arst_n) |-> in_stall && !out_valid)
		else $error("block active during table fill");

endmodule

bind table_mixed_mwc_random_generator tmmrg_checker u_tmmrg_checker (.*);

>>> tb/sv/tmmrg_checker.sv
`timescale 1ns / 1ps

module tmmrg_tb_checker
	import tmmrg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] seed_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] random_value,
	input  logic [31:0] state_out,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [63:0] value;
		logic [31:0] state;
	} draw_result_t;

	logic [31:0] mix_words [TableDepth];
	logic [31:0] rng_state;
	draw_result_t expected_draws[$];
	int fail_count = 0;

	// Rebuilds the mixing table the way the block fills it after reset.
	function automatic void fill_mix_words();
		logic [31:0] mwc_hi;
		logic [31:0] mwc_lo;
		logic [31:0] xs;
		logic [31:0] lcg;
		logic [31:0] mwc;
		mwc_hi = 32'd12345;
		mwc_lo = 32'd65435;
		xs = 32'd34221;
		lcg = 32'd12345;
		for (int i = 0; i < TableDepth; i++) begin
			mwc_hi = 32'd36969 * {16'd0, mwc_hi[15:0]} + {16'd0, mwc_hi[31:16]};
			mwc_lo = 32'd18000 * {16'd0, mwc_lo[15:0]} + {16'd0, mwc_lo[31:16]};
			mwc = (mwc_hi << 16) + mwc_lo;
			lcg = 32'd69069 * lcg + 32'd1234567;
			xs = xs ^ (xs << 17);
			xs = xs ^ (xs >> 13);
			xs = xs ^ (xs << 5);
			mix_words[i] = (mwc ^ lcg) + xs;
		end
	endfunction

	function automatic logic [31:0] next_word();
		logic [31:0] mixed;
		logic [7:0] idx;
		idx = rng_state[19:12];
		mixed = ((32'd36969 * {16'd0, rng_state[31:16]}) << 16)
			+ 32'd18000 * {16'd0, rng_state[15:0]};
		rng_state = mixed ^ ~mix_words[idx];
		return rng_state;
	endfunction

	function automatic draw_result_t predict_draw(input action_t act, input logic [31:0] seed);
		draw_result_t res;
		res.value = 64'd0;
		case (act)
			ACT_DRAW32: begin
				res.value = {32'd0, next_word()};
			end
			ACT_DRAW64: begin
				res.value[63:32] = next_word();
				res.value[31:0] = next_word();
			end
			ACT_RESEED: begin
				rng_state = seed;
			end
			default: begin
			end
		endcase
		res.state = rng_state;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		draw_result_t want;
		if (!arst_n) begin
			rng_state = 32'd0;
			fill_mix_words();
			expected_draws.delete();
			pending <= 0;
			errors <= fail_count;
		end else begin
			if (in_valid && !in_stall)
				expected_draws.push_back(predict_draw(action_t'(action), seed_value));
			if (out_valid && !out_stall) begin
				if (expected_draws.size() == 0) begin
					$error("result transaction with nothing expected: random_value %h state_out %h",
						random_value, state_out);
					fail_count++;
				end else begin
					want = expected_draws.pop_front();
					if (random_value !== want.value) begin
						$error("random_value: expected %h, got %h", want.value, random_value);
						fail_count++;
					end
					if (state_out !== want.state) begin
						$error("state_out: expected %h, got %h", want.state, state_out);
						fail_count++;
					end
				end
			end
			pending <= expected_draws.size();
			errors <= fail_count;
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import tmmrg_pkg::*;

	localparam int RandomItems = 1530;
	localparam int CycleLimit = 250000;
	localparam int TailCycles = 20;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [31:0] seed_value;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] random_value;
	logic [31:0] state_out;
	int          errors;
	int          pending;

	bit quiet_in = 1'b0;
	int sent_count [4] = '{0, 0, 0, 0};
	int cycles = 0;

	table_mixed_mwc_random_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.seed_value   (seed_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.random_value (random_value),
		.state_out    (state_out)
	);

	tmmrg_tb_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.seed_value   (seed_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.random_value (random_value),
		.state_out    (state_out),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Offers one transaction, with a random gap before it unless in the quiet stretch.
	task automatic offer(input action_t act, input logic [31:0] seed);
		while (!quiet_in && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		seed_value <= seed;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count[act]++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, one long hold-off so the block backs up, one quiet stretch.
	initial begin : drain
		int rx_cycle;
		rx_cycle = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= 1500 && rx_cycle < 1800)
				out_stall <= 1'b1;
			else if (rx_cycle >= 2400 && rx_cycle < 3600)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(0, 99) < 16);
		end
	end

	initial begin : stimulus
		int pick;
		logic [31:0] seed;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_DRAW32;
		seed_value <= 32'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: draws from the reset state, seeds at the index and half extremes,
		// and the unused action carrying a seed that must be ignored.
		offer(ACT_DRAW32, 32'd0);
		offer(ACT_DRAW32, 32'hFFFF_FFFF);
		offer(ACT_DRAW64, 32'd0);
		offer(ACT_RESEED, 32'd0);
		offer(ACT_DRAW32, 32'd0);
		offer(ACT_RESEED, 32'hFFFF_FFFF);
		offer(ACT_DRAW32, 32'd0);
		offer(ACT_DRAW64, 32'd0);
		offer(ACT_NONE, 32'hFFFF_FFFF);
		offer(ACT_RESEED, 32'h000F_F000);
		offer(ACT_DRAW32, 32'd0);
		offer(ACT_RESEED, 32'h0000_0FFF);
		offer(ACT_DRAW64, 32'd0);
		offer(ACT_RESEED, 32'hFFF0_0FFF);
		offer(ACT_DRAW32, 32'd0);
		offer(ACT_NONE, 32'd0);
		offer(ACT_RESEED, 32'h8000_0000);
		offer(ACT_DRAW64, 32'hFFFF_FFFF);
		offer(ACT_RESEED, 32'h0000_FFFF);
		offer(ACT_DRAW32, 32'd0);
		offer(ACT_RESEED, 32'hFFFF_0000);
		offer(ACT_DRAW64, 32'd0);
		offer(ACT_NONE, 32'h5A5A_A5A5);
		offer(ACT_DRAW32, 32'd0);

		for (int n = 0; n < RandomItems; n++) begin
			if (n == 400)
				wait_drained();
			quiet_in = (n >= 700 && n < 1000);
			pick = $urandom_range(0, 99);
			seed = $urandom();
			if (pick < 55)
				offer(ACT_DRAW32, seed);
			else if (pick < 80)
				offer(ACT_DRAW64, seed);
			else if (pick < 92) begin
				case ($urandom_range(0, 7))
					0: seed = 32'd0;
					1: seed = 32'hFFFF_FFFF;
					2: seed = seed | 32'h000F_F000;
					3: seed = seed & ~32'h000F_F000;
					default: begin
					end
				endcase
				offer(ACT_RESEED, seed);
			end else
				offer(ACT_NONE, seed);
		end
		quiet_in = 1'b0;

		wait_drained();
		repeat (TailCycles) @(posedge clk);

		$display("Sent %0d 32-bit draws, %0d 64-bit draws, %0d reseeds, %0d unused-action",
			sent_count[ACT_DRAW32], sent_count[ACT_DRAW64], sent_count[ACT_RESEED],
			sent_count[ACT_NONE]);
		$display("transactions with random gaps, a long output hold-off and a full drain.");
		if (pending != 0)
			$error("%0d expected results never arrived", pending);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
